FILE: rtl/bptq_pkg.sv
// Shared types and constants for the bounded priority task queue.
`timescale 1ns / 1ps
`default_nettype none
package bptq_pkg;

   localparam int DEPTH      = 16;
   localparam int PRI_BITS   = 8;
   localparam int TAG_BITS   = 16;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam logic [1:0] MODE_RUNNING   = 2'd0;
   localparam logic [1:0] MODE_SUSPENDED = 2'd1;
   localparam logic [1:0] MODE_CLOSED    = 2'd2;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;

   localparam logic CSR_POOL_MODE = 1'b0;
   localparam logic CSR_CAPACITY  = 1'b1;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_CLOSED    = 3'd3,
      ST_SUSPENDED = 3'd4
   } status_type;

   typedef struct packed {
      logic [PRI_BITS-1:0] pri;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      logic                push;
      logic                pop;
      logic [PRI_BITS-1:0] pri;
      logic [TAG_BITS-1:0] tag;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/bounded_priority_task_queue.sv
// Top level of the bounded priority task queue: control, mode registers and cell chain.
// The queue takes one push or pop every clock cycle unless a stalled result blocks it, and
// returns its result in the cycle after the transfer, held in an output register so that a
// new item is taken in the same cycle in which the last result leaves. Every entry sits in
// its own cell, sorted from the highest priority at slot 0; a push is compared against all
// cells at once and lands behind every entry of equal or higher priority, so equal
// priorities leave in arrival order. The compare of the pushed priority in each cell and
// the shift into the neighbor set the cycle. After reset the pool is suspended with
// capacity 16 and the queue empty; write the pool mode to running before pushing.
`timescale 1ns / 1ps
`default_nettype none
module bounded_priority_task_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // priority_req[7:0], task_tag[23:8]
   input  wire  [0:0]  req_tuser,   // action[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // status[2:0], out_tag[18:3], out_priority[26:19],
                                    // occupancy[31:27]
   input  wire         csr_wen,
   input  wire  [0:0]  csr_index,
   input  wire  [4:0]  csr_wdata
);

   localparam int CB = bptq_pkg::COUNT_BITS;

   logic [1:0]    mode_ff;
   logic [4:0]    capacity_ff;
   logic [CB-1:0] count_ff;
   logic [CB-1:0] count_in;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_data_ff;
   logic [31:0]   rsp_data_in;

   logic                         accept;
   logic                         action;
   logic [bptq_pkg::PRI_BITS-1:0] req_pri;
   logic [bptq_pkg::TAG_BITS-1:0] req_tag;
   logic [CB-1:0]                limit;
   logic                         suspended;
   bptq_pkg::status_type         status;
   bptq_pkg::cell_cmd_type       cmd;

   logic [bptq_pkg::DEPTH-1:0]   held;
   logic [bptq_pkg::DEPTH-1:0]   keep;
   bptq_pkg::entry_type          entries [bptq_pkg::DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign action     = req_tuser[0];
   assign req_pri    = req_tdata[7:0];
   assign req_tag    = req_tdata[23:8];

   // Capacity above the number of cells saturates.
   assign limit = (capacity_ff > 5'(bptq_pkg::DEPTH)) ? CB'(bptq_pkg::DEPTH)
                                                      : CB'(capacity_ff);
   assign suspended = (mode_ff == bptq_pkg::MODE_SUSPENDED) ||
                      (mode_ff == bptq_pkg::MODE_UNUSED);

   always_comb begin
      priority if (suspended) begin
         status = bptq_pkg::ST_SUSPENDED;
      end else if (action == bptq_pkg::ACT_PUSH && mode_ff == bptq_pkg::MODE_CLOSED) begin
         status = bptq_pkg::ST_CLOSED;
      end else if (action == bptq_pkg::ACT_PUSH && count_ff >= limit) begin
         status = bptq_pkg::ST_FULL;
      end else if (action == bptq_pkg::ACT_POP && count_ff == '0) begin
         status = bptq_pkg::ST_EMPTY;
      end else begin
         status = bptq_pkg::ST_OK;
      end
   end

   always_comb begin
      cmd.push = accept && (action == bptq_pkg::ACT_PUSH) && (status == bptq_pkg::ST_OK);
      cmd.pop  = accept && (action == bptq_pkg::ACT_POP) && (status == bptq_pkg::ST_OK);
      cmd.pri  = req_pri;
      cmd.tag  = req_tag;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CB'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CB'(1);
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[2:0]   = status;
      rsp_data_in[31:27] = 5'(count_in);
      if (cmd.pop) begin
         rsp_data_in[18:3]  = entries[0].tag;
         rsp_data_in[26:19] = entries[0].pri;
      end
   end

   genvar g;
   generate
      for (g = 0; g < bptq_pkg::DEPTH; g++) begin : g_cell
         bptq_pkg::entry_type prev_e;
         bptq_pkg::entry_type next_e;
         logic                prev_k;

         assign held[g] = (CB'(g) < count_ff);

         if (g == 0) begin : g_head
            assign prev_k = 1'b1;
            assign prev_e = '0;
         end else begin : g_body
            assign prev_k = keep[g-1];
            assign prev_e = entries[g-1];
         end

         if (g == bptq_pkg::DEPTH - 1) begin : g_tail
            assign next_e = '0;
         end else begin : g_inner
            assign next_e = entries[g+1];
         end

         bptq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .held       (held[g]),
            .prev_keep  (prev_k),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .keep       (keep[g]),
            .entry      (entries[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= bptq_pkg::MODE_SUSPENDED;
         capacity_ff  <= 5'(bptq_pkg::DEPTH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index[0])
               bptq_pkg::CSR_POOL_MODE: mode_ff     <= csr_wdata[1:0];
               bptq_pkg::CSR_CAPACITY:  capacity_ff <= csr_wdata;
               default:                 mode_ff     <= mode_ff;
            endcase
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The fill count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(bptq_pkg::DEPTH))
      else $error("queue count beyond depth");

   // A successful push grows the queue by one entry.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> count_ff == $past(count_ff) + CB'(1))
      else $error("push did not grow the queue");

   // While two or more entries are held, the head slot holds a priority no lower than the second slot.
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CB'(2)) |-> (entries[0].pri >= entries[1].pri))
      else $error("queue head out of order");

   // Every accepted item leaves a result waiting in the next cycle.
   a_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule
`default_nettype wire

FILE: rtl/bptq_cell.sv
// One slot of the sorted shift-register queue.
`timescale 1ns / 1ps
`default_nettype none
module bptq_cell (
   input  wire                    clock,
   input  bptq_pkg::cell_cmd_type cmd,
   input  wire                    held,       // slot lies below the fill count
   input  wire                    prev_keep,  // left neighbor keeps its entry on a push
   input  bptq_pkg::entry_type    prev_entry,
   input  bptq_pkg::entry_type    next_entry,
   output logic                   keep,
   output bptq_pkg::entry_type    entry
);

   bptq_pkg::entry_type entry_ff;
   bptq_pkg::entry_type entry_in;
   logic                load;

   // An entry of equal or larger priority stays ahead of the new task.
   assign keep = held && (entry_ff.pri >= cmd.pri);

   always_comb begin
      load     = 1'b0;
      entry_in = entry_ff;
      if (cmd.pop) begin
         load     = 1'b1;
         entry_in = next_entry;
      end else if (cmd.push && !keep) begin
         load = 1'b1;
         if (prev_keep) begin
            entry_in.pri = cmd.pri;
            entry_in.tag = cmd.tag;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire
